// File: hdl/mutex_ownership_table_top_assert.svh
// ----------------------------------------------------------------------------
// mutex_ownership_table_top_assert.svh
// Assertion macros used by the mutex table top-level RTL.
// ----------------------------------------------------------------------------
`ifndef MUTEX_OWNERSHIP_TABLE_TOP_ASSERT_SVH
`define MUTEX_OWNERSHIP_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define MOT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mutex table check failed");

// Next-cycle implication, disabled while in reset
`define MOT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mutex table check failed");

`endif

// File: hdl/mot_pkg.sv
// ----------------------------------------------------------------------------
// mot_pkg
// Types and constants shared by the mutex ownership table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mot_pkg;

   // Fixed field widths of the request and response channels
   localparam int INDEX_BITS  = 8;
   localparam int CALLER_BITS = 8;

   // Entries examined per cycle by the free-entry scanner
   localparam int SCAN_CHUNK  = 8;
   localparam int OFFSET_BITS = $clog2(SCAN_CHUNK);

   typedef enum logic [1:0] {
      OP_CREATE  = 2'd0,
      OP_DESTROY = 2'd1,
      OP_LOCK    = 2'd2,
      OP_UNLOCK  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FAIL = 2'd1,
      STATUS_BUSY = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type              opcode;
      logic [INDEX_BITS-1:0]   mutex_index;
      logic [CALLER_BITS-1:0]  caller_id;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [INDEX_BITS-1:0]   granted_index;
   } rsp_type;

   // Scanner report to the sequencer
   typedef struct packed {
      logic                    done;
      logic                    found;
      logic [INDEX_BITS-1:0]   index;
   } scan_type;

endpackage

`default_nettype wire

// File: hdl/mot_owner_ram.sv
// ----------------------------------------------------------------------------
// mot_owner_ram
// Owner id store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mot_owner_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/mot_scan.sv
// ----------------------------------------------------------------------------
// mot_scan
// Free-entry scanner: steps through the free vector one chunk per cycle and
// reports the lowest free entry, or that none is free.
// ----------------------------------------------------------------------------
`default_nettype none

module mot_scan #(
   parameter int ENTRIES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [ENTRIES-1:0] free_vec,
   output mot_pkg::scan_type       scan
);

   localparam int NCHUNK   = (ENTRIES + mot_pkg::SCAN_CHUNK - 1) / mot_pkg::SCAN_CHUNK;
   localparam int CNT_BITS = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int PAD_BITS = NCHUNK * mot_pkg::SCAN_CHUNK;

   logic                                busy_ff, busy_in;
   logic [CNT_BITS-1:0]                 chunk_ff, chunk_in;
   logic [PAD_BITS-1:0]                 free_pad;
   logic [mot_pkg::SCAN_CHUNK-1:0]      chunk_bits;
   logic [mot_pkg::OFFSET_BITS-1:0]     offset;
   logic                                hit;
   logic                                last;

   // Pad the free vector to whole chunks with non-free entries
   assign free_pad   = PAD_BITS'(free_vec);
   assign chunk_bits = free_pad[chunk_ff * mot_pkg::SCAN_CHUNK +: mot_pkg::SCAN_CHUNK];
   assign hit        = |chunk_bits;
   assign last       = (chunk_ff == CNT_BITS'(NCHUNK - 1));

   // Find the lowest free entry inside the current chunk
   always_comb begin
      offset = '0;
      for (int i = mot_pkg::SCAN_CHUNK - 1; i >= 0; i--) begin
         if (chunk_bits[i]) begin
            offset = mot_pkg::OFFSET_BITS'(i);
         end
      end
   end

   always_comb begin
      scan.done  = busy_ff && (hit || last);
      scan.found = busy_ff && hit;
      scan.index = mot_pkg::INDEX_BITS'({chunk_ff, offset});
   end

   // Advance one chunk per cycle until a hit or the last chunk
   always_comb begin
      busy_in  = busy_ff;
      chunk_in = chunk_ff;
      if (start) begin
         busy_in  = 1'b1;
         chunk_in = '0;
      end else if (scan.done) begin
         busy_in  = 1'b0;
      end else if (busy_ff) begin
         chunk_in = chunk_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         chunk_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         chunk_ff <= chunk_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/mutex_ownership_table_top.sv
// ----------------------------------------------------------------------------
// mutex_ownership_table_top
// Table of ENTRIES mutexes with create, destroy, lock and unlock requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ channel (valid/ready), one opcode, index and
//   caller id per transfer. Every request yields exactly one response on the
//   rsp_ channel: a status and, for a successful create, the granted index.
//   The block serves one request at a time; req_ready is low from the accept
//   until the response transfer completes.
//   Destroy, lock and unlock pass through ST_EXEC, which decides from the
//   owner store read registered at the accept, then answer from ST_RESP.
//   Create runs the free-entry scanner in ST_SCAN, which covers 8 entries a
//   cycle and stops at the first chunk that holds a free entry or the last.
//   The next request is taken only after the response transfer completes.
//   Reset clears all lock and reserved marks at once; owner ids need no
//   clearing since they are only read for locked entries.
//   A stalled receiver holds the response registered and stable; no new
//   request is taken until it is transferred.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mutex_ownership_table_top_assert.svh"

module mutex_ownership_table_top #(
   parameter int ENTRIES    = 64,
   parameter int OWNER_BITS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mot_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mot_pkg::rsp_type      rsp_data
);

   localparam int IDX_BITS = $clog2(ENTRIES);
   localparam logic [mot_pkg::INDEX_BITS:0] ENTRIES_LIMIT = (mot_pkg::INDEX_BITS + 1)'(ENTRIES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC,
      ST_RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [ENTRIES-1:0]   lock_ff, lock_in;
   logic [ENTRIES-1:0]   reserved_ff, reserved_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mot_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   mot_pkg::req_type     req_ff, req_in;

   logic                 req_xfer;
   logic                 scan_start;
   mot_pkg::scan_type    scan;
   logic                 ram_wr_en;
   logic [OWNER_BITS-1:0] owner_rd;
   logic [OWNER_BITS-1:0] who;
   logic [IDX_BITS-1:0]  idx;
   logic                 in_range;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Start the scan on a create transfer
   assign scan_start = req_xfer && (req_data.opcode == mot_pkg::OP_CREATE);

   assign idx      = req_ff.mutex_index[IDX_BITS-1:0];
   assign in_range = ({1'b0, req_ff.mutex_index} < ENTRIES_LIMIT);
   assign who      = OWNER_BITS'(req_ff.caller_id);

   mot_scan #(
      .ENTRIES (ENTRIES)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_start),
      .free_vec (~lock_ff & ~reserved_ff),
      .scan     (scan)
   );

   mot_owner_ram #(
      .DEPTH (ENTRIES),
      .WIDTH (OWNER_BITS)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx),
      .wr_data (who),
      .rd_en   (req_xfer),
      .rd_addr (req_data.mutex_index[IDX_BITS-1:0]),
      .rd_data (owner_rd)
   );

   // Sequence one request: take it, scan or decide, then hold the response
   always_comb begin
      state_in     = state_ff;
      lock_in      = lock_ff;
      reserved_in  = reserved_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_in       = req_ff;
      ram_wr_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               req_in   = req_data;
               state_in = (req_data.opcode == mot_pkg::OP_CREATE) ? ST_SCAN : ST_EXEC;
            end
         end
         ST_SCAN: begin
            if (scan.done) begin
               rsp_data_in.status        = mot_pkg::STATUS_FAIL;
               rsp_data_in.granted_index = '0;
               if (scan.found) begin
                  reserved_in[scan.index[IDX_BITS-1:0]] = 1'b1;
                  rsp_data_in.status        = mot_pkg::STATUS_OK;
                  rsp_data_in.granted_index = scan.index;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_EXEC: begin
            rsp_data_in.status        = mot_pkg::STATUS_FAIL;
            rsp_data_in.granted_index = '0;
            if (in_range) begin
               case (req_ff.opcode)
                  mot_pkg::OP_DESTROY: begin
                     if (!lock_ff[idx]) begin
                        reserved_in[idx]   = 1'b0;
                        rsp_data_in.status = mot_pkg::STATUS_OK;
                     end
                  end
                  mot_pkg::OP_LOCK: begin
                     if (lock_ff[idx]) begin
                        rsp_data_in.status = mot_pkg::STATUS_BUSY;
                     end else begin
                        lock_in[idx]       = 1'b1;
                        reserved_in[idx]   = 1'b0;
                        ram_wr_en          = 1'b1;
                        rsp_data_in.status = mot_pkg::STATUS_OK;
                     end
                  end
                  mot_pkg::OP_UNLOCK: begin
                     if (lock_ff[idx] && (owner_rd == who)) begin
                        lock_in[idx]       = 1'b0;
                        reserved_in[idx]   = 1'b0;
                        rsp_data_in.status = mot_pkg::STATUS_OK;
                     end
                  end
                  default: begin
                     rsp_data_in.status = mot_pkg::STATUS_FAIL;
                  end
               endcase
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, table marks and the registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lock_ff      <= '0;
         reserved_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lock_ff      <= lock_in;
         reserved_ff  <= reserved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      req_ff      <= req_in;
   end

   // No entry is both locked and reserved
   `MOT_ASSERT_IMPLY(a_lock_excl_reserved, clock, reset, 1'b1, ((lock_ff & reserved_ff) == '0))
   // A pending response blocks new requests
   `MOT_ASSERT_IMPLY(a_rsp_blocks_req, clock, reset, rsp_valid, !req_ready)
   // A transfer closes the request port in the next cycle
   `MOT_ASSERT_NEXT(a_accept_closes, clock, reset, req_xfer, !req_ready)
   // Only a successful create reports a nonzero granted index
   `MOT_ASSERT_IMPLY(a_grant_zero, clock, reset, rsp_valid && (rsp_data.status != mot_pkg::STATUS_OK || req_ff.opcode != mot_pkg::OP_CREATE), (rsp_data.granted_index == '0))

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for mutex_ownership_table_top.
// Sends create, destroy, lock and unlock requests, first directed and then
// random. Both channels idle in random bursts. A shadow copy of the table
// predicts each response, and every response is checked field by field.
// ----------------------------------------------------------------------------

module tb;

   localparam int TABLE_ENTRIES = 64;
   localparam int OWNER_WIDTH   = 8;
   localparam int CALLER_POOL   = 4;
   localparam int SETTLE_CYCLES = 20;
   localparam longint RUN_LIMIT_NS = 5_000_000;

   // Highest valid index and lowest out-of-range index
   localparam logic [mot_pkg::INDEX_BITS-1:0] LAST_INDEX =
      mot_pkg::INDEX_BITS'(TABLE_ENTRIES - 1);
   localparam logic [mot_pkg::INDEX_BITS-1:0] FIRST_BAD_INDEX =
      mot_pkg::INDEX_BITS'(TABLE_ENTRIES);

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   mot_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   mot_pkg::rsp_type rsp_data;

   // Shadow copy of the mutex table
   bit                     mutex_locked   [TABLE_ENTRIES];
   bit                     mutex_reserved [TABLE_ENTRIES];
   logic [OWNER_WIDTH-1:0] mutex_owner    [TABLE_ENTRIES];

   mot_pkg::rsp_type pending_rsp[$];
   mot_pkg::rsp_type want_rsp;
   int      error_count;
   int      rsp_count;
   int      full_count;
   int      op_count[4];
   int      status_count[4];
   bit      gaps_on;
   int      stall_left;

   mutex_ownership_table_top #(
      .ENTRIES    (TABLE_ENTRIES),
      .OWNER_BITS (OWNER_WIDTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one request to the shadow table and return the response it gives
   function automatic mot_pkg::rsp_type predict_response(mot_pkg::req_type r);
      mot_pkg::rsp_type       p;
      logic [OWNER_WIDTH-1:0] who;
      int                     slot;
      p.status        = mot_pkg::STATUS_FAIL;
      p.granted_index = '0;
      who             = r.caller_id[OWNER_WIDTH-1:0];
      slot            = r.mutex_index;
      if (r.opcode == mot_pkg::OP_CREATE) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!mutex_locked[i] && !mutex_reserved[i]) begin
               mutex_reserved[i] = 1'b1;
               mutex_owner[i]    = '0;
               p.status          = mot_pkg::STATUS_OK;
               p.granted_index   = mot_pkg::INDEX_BITS'(i);
               break;
            end
         end
         if (p.status == mot_pkg::STATUS_FAIL) full_count++;
      end else if (slot < TABLE_ENTRIES) begin
         case (r.opcode)
            mot_pkg::OP_DESTROY: begin
               if (!mutex_locked[slot]) begin
                  mutex_reserved[slot] = 1'b0;
                  mutex_owner[slot]    = '0;
                  p.status             = mot_pkg::STATUS_OK;
               end
            end
            mot_pkg::OP_LOCK: begin
               if (mutex_locked[slot]) begin
                  p.status = mot_pkg::STATUS_BUSY;
               end else begin
                  mutex_locked[slot]   = 1'b1;
                  mutex_reserved[slot] = 1'b0;
                  mutex_owner[slot]    = who;
                  p.status             = mot_pkg::STATUS_OK;
               end
            end
            default: begin
               if (mutex_locked[slot] && mutex_owner[slot] == who) begin
                  mutex_locked[slot]   = 1'b0;
                  mutex_reserved[slot] = 1'b0;
                  mutex_owner[slot]    = '0;
                  p.status             = mot_pkg::STATUS_OK;
               end
            end
         endcase
      end
      return p;
   endfunction

   // Low indices are favored so that callers collide on the same entries
   function automatic int pick_index();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 7);
      return $urandom_range(0, TABLE_ENTRIES - 1);
   endfunction

   function automatic int pick_caller();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 255);
      return $urandom_range(1, CALLER_POOL);
   endfunction

   // Random entry that is locked or reserved; any index if there is none
   function automatic int find_entry(bit want_locked);
      int hits[$];
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (want_locked ? mutex_locked[i] : mutex_reserved[i]) hits.push_back(i);
      end
      if (hits.size() == 0) return pick_index();
      return hits[$urandom_range(0, hits.size() - 1)];
   endfunction

   // Drive one request, hold it until transfer, record its expected response
   task automatic send_request(mot_pkg::opcode_type op,
                               logic [mot_pkg::INDEX_BITS-1:0] idx,
                               logic [mot_pkg::CALLER_BITS-1:0] caller);
      int gap;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         repeat (gap) @(negedge clock);
      end
      req_data.opcode      = op;
      req_data.mutex_index = idx;
      req_data.caller_id   = caller;
      req_valid            = 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(predict_response(req_data));
      op_count[op]++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Hold off the sender until every expected response has arrived
   task automatic wait_for_responses();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic test_basic_ops();
      send_request(mot_pkg::OP_CREATE, 8'h00, 8'd1);
      send_request(mot_pkg::OP_CREATE, 8'hFF, 8'd1);
      // Locking a reserved entry turns the reservation into ownership
      send_request(mot_pkg::OP_LOCK, 8'd0, 8'd5);
      send_request(mot_pkg::OP_LOCK, 8'd0, 8'd5);
      send_request(mot_pkg::OP_LOCK, 8'd0, 8'd9);
      send_request(mot_pkg::OP_UNLOCK, 8'd0, 8'd9);
      send_request(mot_pkg::OP_UNLOCK, 8'd0, 8'd5);
      send_request(mot_pkg::OP_UNLOCK, 8'd0, 8'd5);
      // Entry never created, caller id zero
      send_request(mot_pkg::OP_LOCK, LAST_INDEX, 8'd0);
      send_request(mot_pkg::OP_DESTROY, LAST_INDEX, 8'd3);
      send_request(mot_pkg::OP_UNLOCK, LAST_INDEX, 8'd0);
      send_request(mot_pkg::OP_DESTROY, LAST_INDEX, 8'd3);
      send_request(mot_pkg::OP_DESTROY, 8'd1, 8'd2);
      send_request(mot_pkg::OP_CREATE, 8'h00, 8'hFF);
      send_request(mot_pkg::OP_LOCK, 8'd2, 8'hFF);
      send_request(mot_pkg::OP_UNLOCK, 8'd2, 8'hFF);
      wait_for_responses();
   endtask

   task automatic test_bad_index();
      logic [mot_pkg::INDEX_BITS-1:0] bad_idx[3];
      bad_idx = '{FIRST_BAD_INDEX, 8'h80, 8'hFF};
      foreach (bad_idx[k]) begin
         send_request(mot_pkg::OP_DESTROY, bad_idx[k], 8'd1);
         send_request(mot_pkg::OP_LOCK, bad_idx[k], 8'hAA);
         send_request(mot_pkg::OP_UNLOCK, bad_idx[k], 8'h55);
      end
      wait_for_responses();
   endtask

   // Fill every free entry, then create once more on the full table
   task automatic test_table_full();
      int free_left;
      free_left = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (!mutex_locked[i] && !mutex_reserved[i]) free_left++;
      end
      repeat (free_left) begin
         send_request(mot_pkg::OP_CREATE, mot_pkg::INDEX_BITS'($urandom_range(0, 255)),
                      mot_pkg::CALLER_BITS'(pick_caller()));
      end
      send_request(mot_pkg::OP_CREATE, 8'hFF, 8'hFF);
      send_request(mot_pkg::OP_LOCK, LAST_INDEX, 8'd7);
      send_request(mot_pkg::OP_CREATE, 8'h00, 8'd1);
      send_request(mot_pkg::OP_UNLOCK, LAST_INDEX, 8'd7);
      send_request(mot_pkg::OP_CREATE, 8'h00, 8'd1);
      wait_for_responses();
   endtask

   // Mostly meaningful requests against entries in use, some noise
   task automatic test_random_traffic(int count, bit with_gaps);
      int                  roll;
      int                  idx;
      int                  who;
      mot_pkg::opcode_type op;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) gaps_on = with_gaps && ($urandom_range(0, 3) != 0);
         roll = $urandom_range(0, 99);
         idx  = pick_index();
         who  = pick_caller();
         if (roll < 22) begin
            op = mot_pkg::OP_CREATE;
         end else if (roll < 34) begin
            op = mot_pkg::OP_LOCK;
         end else if (roll < 44) begin
            op  = mot_pkg::OP_LOCK;
            idx = find_entry(1'b0);
         end else if (roll < 60) begin
            op  = mot_pkg::OP_UNLOCK;
            idx = find_entry(1'b1);
            if (mutex_locked[idx] && $urandom_range(0, 4) != 0) who = mutex_owner[idx];
         end else if (roll < 68) begin
            op = mot_pkg::OP_UNLOCK;
         end else if (roll < 78) begin
            op = mot_pkg::OP_DESTROY;
         end else if (roll < 88) begin
            op  = mot_pkg::OP_DESTROY;
            idx = find_entry(1'b0);
         end else if (roll < 94) begin
            op  = mot_pkg::OP_LOCK;
            idx = find_entry(1'b1);
         end else begin
            op  = mot_pkg::opcode_type'($urandom_range(0, 3));
            idx = $urandom_range(TABLE_ENTRIES, 255);
         end
         send_request(op, mot_pkg::INDEX_BITS'(idx), mot_pkg::CALLER_BITS'(who));
      end
   endtask

   // Random receiver stalls in bursts, only while gaps are on
   initial begin
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (gaps_on && stall_left == 0 && $urandom_range(0, 3) == 0)
            stall_left = $urandom_range(1, 5);
         if (gaps_on && stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready  = 1'b1;
            stall_left = 0;
         end
      end
   end

   // Compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response status=%0d granted_index=%0d",
                     $time, rsp_data.status, rsp_data.granted_index);
         end else begin
            want_rsp = pending_rsp.pop_front();
            status_count[want_rsp.status]++;
            if (rsp_data.status !== want_rsp.status) begin
               error_count++;
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want_rsp.status, rsp_data.status);
            end
            if (rsp_data.granted_index !== want_rsp.granted_index) begin
               error_count++;
               $display("%0t: granted_index mismatch: expected %0d, actual %0d",
                        $time, want_rsp.granted_index, rsp_data.granted_index);
            end
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("%0t: run limit reached with %0d responses outstanding",
               $time, pending_rsp.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      gaps_on     = 1'b1;
      error_count = 0;
      rsp_count   = 0;
      full_count  = 0;
      op_count     = '{default: 0};
      status_count = '{default: 0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_ops();
      test_bad_index();
      test_table_full();
      test_random_traffic(1000, 1'b1);
      wait_for_responses();
      // Final stretch at full rate on both sides
      test_random_traffic(200, 1'b0);
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d requests (create %0d, destroy %0d, lock %0d, unlock %0d)",
               op_count.sum(), op_count[mot_pkg::OP_CREATE], op_count[mot_pkg::OP_DESTROY],
               op_count[mot_pkg::OP_LOCK], op_count[mot_pkg::OP_UNLOCK]);
      $display("%0d responses: ok %0d, fail %0d, busy %0d; create on a full table %0d times",
               rsp_count, status_count[mot_pkg::STATUS_OK],
               status_count[mot_pkg::STATUS_FAIL],
               status_count[mot_pkg::STATUS_BUSY], full_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
